FILE: rtl/core/qfr_pkg.sv
// Shared types, widths and helper functions for the rotation-matrix-to-quaternion pipeline.
// Used by every module in rtl/core; depends on nothing else.
package qfr_pkg;

	localparam int DW        = 16;                       // element and component width
	localparam int FRAC_BITS = 14;                       // fraction bits, 1.0 is 2**FRAC_BITS
	localparam int RBITS     = 12;                       // extra scaling of the root argument
	localparam int TW        = (DW + 3 > 18) ? DW + 3 : 18; // signed trace term width
	localparam int AW0       = TW - 1 + RBITS;
	localparam int AW        = AW0 + (AW0 % 2);          // root argument width, even
	localparam int MW        = AW / 2;                   // floor root width
	localparam int RW        = MW + 2;                   // root remainder width
	localparam int NW        = DW + RBITS + 2;           // dividend and quotient width

	localparam logic signed [TW-1:0] ONE_T  = TW'(1 << FRAC_BITS);
	localparam logic signed [NW:0]   SAT_HI = (NW+1)'((1 << (DW - 1)) - 1);
	localparam logic signed [NW:0]   SAT_LO = -SAT_HI - (NW+1)'(1);

	typedef logic signed [DW-1:0] elem_t;
	typedef logic signed [DW:0]   diff_t;

	typedef enum logic [1:0] {
		BR_W = 2'd0,
		BR_X = 2'd1,
		BR_Y = 2'd2,
		BR_Z = 2'd3
	} branch_t;

	// Item tag carried along the whole pipeline.
	typedef struct packed {
		branch_t br;
		logic    degen;
		diff_t   d0;
		diff_t   d1;
		diff_t   d2;
	} tag_t;

	// Payload of the square root stages.
	typedef struct packed {
		tag_t          tag;
		logic [AW-1:0] rad;
		logic [MW-1:0] root;
		logic [RW-1:0] rem;
	} sq_t;

	// One divider lane.
	typedef struct packed {
		logic [NW-1:0] num;
		logic [MW:0]   rem;
		logic [NW-1:0] quo;
	} lane_t;

	// Payload of the divider stages.
	typedef struct packed {
		tag_t             tag;
		logic [MW:0]      m;
		lane_t [2:0]      ln;
	} dv_t;

	// Magnitude of a signed difference as an unsigned value.
	function automatic logic [DW:0] mag_of(input diff_t d);
		logic [DW:0] r;
		r = d[DW] ? (~d + (DW+1)'(1)) : d;
		return r;
	endfunction

	// Saturate a wide signed value to the component width.
	function automatic elem_t sat_of(input logic signed [NW:0] v);
		elem_t r;
		if (v > SAT_HI) begin
			r = SAT_HI[DW-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[DW-1:0];
		end else begin
			r = v[DW-1:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/qfr_front.sv
// First stage: branch selection, trace term, root argument and element differences.
// Depends on qfr_pkg.
module qfr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  qfr_pkg::elem_t a00,
	input  qfr_pkg::elem_t a01,
	input  qfr_pkg::elem_t a02,
	input  qfr_pkg::elem_t a10,
	input  qfr_pkg::elem_t a11,
	input  qfr_pkg::elem_t a12,
	input  qfr_pkg::elem_t a20,
	input  qfr_pkg::elem_t a21,
	input  qfr_pkg::elem_t a22,
	output logic          out_valid,
	input  logic          out_ready,
	output qfr_pkg::sq_t  out_data
);
	import qfr_pkg::*;

	diff_t s48, d48, s04, d04, s08, d08;
	logic signed [TW-1:0] t;
	branch_t br;
	sq_t nxt;
	sq_t data_s1;
	logic vld_s1;
	logic en;

	assign s48 = (DW+1)'(a11) + (DW+1)'(a22);
	assign d48 = (DW+1)'(a11) - (DW+1)'(a22);
	assign s04 = (DW+1)'(a00) + (DW+1)'(a11);
	assign d04 = (DW+1)'(a00) - (DW+1)'(a11);
	assign s08 = (DW+1)'(a00) + (DW+1)'(a22);
	assign d08 = (DW+1)'(a00) - (DW+1)'(a22);

	always_comb begin
		priority if (s48 > 0 && s04 > 0 && s08 > 0) begin
			br = BR_W;
		end else if (s48 < 0 && d04 > 0 && d08 > 0) begin
			br = BR_X;
		end else if (d48 > 0 && d04 < 0 && s08 < 0) begin
			br = BR_Y;
		end else if (d48 < 0 && s04 < 0 && d08 < 0) begin
			br = BR_Z;
		end else begin
			br = BR_W;
		end
	end

	always_comb begin
		unique case (br)
			BR_X: begin
				t = ONE_T + TW'(a00) - TW'(a11) - TW'(a22);
			end
			BR_Y: begin
				t = ONE_T + TW'(a11) - TW'(a22) - TW'(a00);
			end
			BR_Z: begin
				t = ONE_T + TW'(a22) - TW'(a00) - TW'(a11);
			end
			default: begin
				t = ONE_T + TW'(a00) + TW'(a11) + TW'(a22);
			end
		endcase
	end

	always_comb begin
		nxt = '0;
		nxt.tag.br    = br;
		nxt.tag.degen = (t <= 0);
		nxt.rad       = nxt.tag.degen ? '0 : (AW'(t[TW-2:0]) << RBITS);
		unique case (br)
			BR_X: begin
				nxt.tag.d0 = (DW+1)'(a12) - (DW+1)'(a21);
				nxt.tag.d1 = (DW+1)'(a01) + (DW+1)'(a10);
				nxt.tag.d2 = (DW+1)'(a20) + (DW+1)'(a02);
			end
			BR_Y: begin
				nxt.tag.d0 = (DW+1)'(a20) - (DW+1)'(a02);
				nxt.tag.d1 = (DW+1)'(a01) + (DW+1)'(a10);
				nxt.tag.d2 = (DW+1)'(a12) + (DW+1)'(a21);
			end
			BR_Z: begin
				nxt.tag.d0 = (DW+1)'(a01) - (DW+1)'(a10);
				nxt.tag.d1 = (DW+1)'(a20) + (DW+1)'(a02);
				nxt.tag.d2 = (DW+1)'(a12) + (DW+1)'(a21);
			end
			default: begin
				nxt.tag.d0 = (DW+1)'(a12) - (DW+1)'(a21);
				nxt.tag.d1 = (DW+1)'(a20) - (DW+1)'(a02);
				nxt.tag.d2 = (DW+1)'(a01) - (DW+1)'(a10);
			end
		endcase
	end

	assign en       = !vld_s1 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign out_data  = data_s1;

endmodule

FILE: rtl/core/qfr_sqrt.sv
// Pipelined square root, one root bit per stage, with a rounding stage that
// also builds the divider dividends. Depends on qfr_pkg.
module qfr_sqrt (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  qfr_pkg::sq_t in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output qfr_pkg::dv_t out_data
);
	import qfr_pkg::*;

	sq_t  stg_s [MW];
	logic vld_s [MW];
	logic en    [MW];
	logic en_r;
	logic vld_r_q;
	dv_t  rnd_q;
	dv_t  rnd_nxt;

	genvar k;
	generate
		for (k = 0; k < MW; k++) begin : g_stg
			sq_t src;
			sq_t nxt;
			logic src_v;
			logic [RW-1:0] r2, tr;

			if (k == 0) begin : g_first
				assign src   = in_data;
				assign src_v = in_valid;
			end else begin : g_next
				assign src   = stg_s[k-1];
				assign src_v = vld_s[k-1];
			end

			if (k == MW - 1) begin : g_last_en
				assign en[k] = !vld_s[k] || en_r;
			end else begin : g_mid_en
				assign en[k] = !vld_s[k] || en[k+1];
			end

			assign r2 = {src.rem[RW-3:0], src.rad[2*(MW-1-k)+1 -: 2]};
			assign tr = {src.root, 2'b01};

			always_comb begin
				nxt = src;
				if (r2 >= tr) begin
					nxt.rem  = r2 - tr;
					nxt.root = {src.root[MW-2:0], 1'b1};
				end else begin
					nxt.rem  = r2;
					nxt.root = {src.root[MW-2:0], 1'b0};
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (en[k]) begin
					vld_s[k] <= src_v;
				end
			end

			always_ff @(posedge clk) begin
				if (en[k]) begin
					stg_s[k] <= nxt;
				end
			end
		end
	endgenerate

	// Round to nearest: step up when the remainder exceeds the floor root.
	always_comb begin
		logic [MW:0] m;
		m = {1'b0, stg_s[MW-1].root} +
			(MW+1)'(stg_s[MW-1].rem > RW'(stg_s[MW-1].root));
		rnd_nxt            = '0;
		rnd_nxt.tag        = stg_s[MW-1].tag;
		rnd_nxt.m          = m;
		rnd_nxt.ln[0].num  = (NW'(mag_of(stg_s[MW-1].tag.d0)) << RBITS) + NW'(m >> 1);
		rnd_nxt.ln[1].num  = (NW'(mag_of(stg_s[MW-1].tag.d1)) << RBITS) + NW'(m >> 1);
		rnd_nxt.ln[2].num  = (NW'(mag_of(stg_s[MW-1].tag.d2)) << RBITS) + NW'(m >> 1);
	end

	assign en_r     = !vld_r_q || out_ready;
	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_r_q <= 1'b0;
		end else if (en_r) begin
			vld_r_q <= vld_s[MW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_r) begin
			rnd_q <= rnd_nxt;
		end
	end

	assign out_valid = vld_r_q;
	assign out_data  = rnd_q;

endmodule

FILE: rtl/core/qfr_div.sv
// Three-lane pipelined restoring divider, one quotient bit per stage.
// Depends on qfr_pkg.
module qfr_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  qfr_pkg::dv_t in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output qfr_pkg::dv_t out_data
);
	import qfr_pkg::*;

	dv_t  stg_s [NW];
	logic vld_s [NW];
	logic en    [NW];

	genvar k;
	generate
		for (k = 0; k < NW; k++) begin : g_stg
			dv_t src;
			dv_t nxt;
			logic src_v;

			if (k == 0) begin : g_first
				assign src   = in_data;
				assign src_v = in_valid;
			end else begin : g_next
				assign src   = stg_s[k-1];
				assign src_v = vld_s[k-1];
			end

			if (k == NW - 1) begin : g_last_en
				assign en[k] = !vld_s[k] || out_ready;
			end else begin : g_mid_en
				assign en[k] = !vld_s[k] || en[k+1];
			end

			always_comb begin
				logic [MW+1:0] r2;
				nxt = src;
				for (int j = 0; j < 3; j++) begin
					r2 = {src.ln[j].rem, src.ln[j].num[NW-1-k]};
					if (r2 >= {1'b0, src.m}) begin
						nxt.ln[j].rem = (MW+1)'(r2 - {1'b0, src.m});
						nxt.ln[j].quo = {src.ln[j].quo[NW-2:0], 1'b1};
					end else begin
						nxt.ln[j].rem = r2[MW:0];
						nxt.ln[j].quo = {src.ln[j].quo[NW-2:0], 1'b0};
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (en[k]) begin
					vld_s[k] <= src_v;
				end
			end

			always_ff @(posedge clk) begin
				if (en[k]) begin
					stg_s[k] <= nxt;
				end
			end
		end
	endgenerate

	assign in_ready  = en[0];
	assign out_valid = vld_s[NW-1];
	assign out_data  = stg_s[NW-1];

endmodule

FILE: rtl/core/qfr_back.sv
// Output stage: sign restore, component placement, scalar sign fix, saturation.
// Depends on qfr_pkg.
module qfr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  qfr_pkg::dv_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output qfr_pkg::elem_t quat_w,
	output qfr_pkg::elem_t quat_x,
	output qfr_pkg::elem_t quat_y,
	output qfr_pkg::elem_t quat_z,
	output logic [1:0]     branch,
	output logic           degenerate
);
	import qfr_pkg::*;

	logic signed [NW:0] lv [3];
	logic signed [NW:0] mv;
	logic signed [NW:0] cw, cx, cy, cz;
	elem_t w_nxt, x_nxt, y_nxt, z_nxt;
	elem_t w_q, x_q, y_q, z_q;
	logic [1:0] br_q;
	logic degen_q;
	logic vld_q;
	logic en;

	always_comb begin
		diff_t d [3];
		d[0] = in_data.tag.d0;
		d[1] = in_data.tag.d1;
		d[2] = in_data.tag.d2;
		for (int j = 0; j < 3; j++) begin
			lv[j] = d[j][DW] ? -$signed({1'b0, in_data.ln[j].quo})
				: $signed({1'b0, in_data.ln[j].quo});
		end
	end

	assign mv = $signed({{(NW-MW){1'b0}}, in_data.m});

	always_comb begin
		unique case (in_data.tag.br)
			BR_X: begin
				cw = lv[0]; cx = mv; cy = lv[1]; cz = lv[2];
			end
			BR_Y: begin
				cw = lv[0]; cx = lv[1]; cy = mv; cz = lv[2];
			end
			BR_Z: begin
				cw = lv[0]; cx = lv[1]; cy = lv[2]; cz = mv;
			end
			default: begin
				cw = mv; cx = lv[0]; cy = lv[1]; cz = lv[2];
			end
		endcase
	end

	always_comb begin
		if (in_data.tag.degen) begin
			w_nxt = '0; x_nxt = '0; y_nxt = '0; z_nxt = '0;
		end else if (cw < 0) begin
			w_nxt = sat_of(-cw); x_nxt = sat_of(-cx);
			y_nxt = sat_of(-cy); z_nxt = sat_of(-cz);
		end else begin
			w_nxt = sat_of(cw); x_nxt = sat_of(cx);
			y_nxt = sat_of(cy); z_nxt = sat_of(cz);
		end
	end

	assign en       = !vld_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_q     <= w_nxt;
			x_q     <= x_nxt;
			y_q     <= y_nxt;
			z_q     <= z_nxt;
			br_q    <= in_data.tag.br;
			degen_q <= in_data.tag.degen;
		end
	end

	assign out_valid  = vld_q;
	assign quat_w     = w_q;
	assign quat_x     = x_q;
	assign quat_y     = y_q;
	assign quat_z     = z_q;
	assign branch     = br_q;
	assign degenerate = degen_q;

endmodule

FILE: rtl/core/quaternion_from_rotation_matrix_top.sv
// Rotation matrix to quaternion converter, fully pipelined. One matrix word is
// accepted and one quaternion word leaves every cycle while out_ready is high.
// Words pass the front end, square root (one root bit per stage), rounding,
// divider (one quotient bit per stage, three lanes in parallel) and output
// stages. Each stage has its own valid bit and advances whenever the stage
// after it is empty or moving, so bubbles close up under back pressure and
// nothing is dropped or repeated. Elements and components are signed Q1.14.
// The branch is chosen from the diagonal, the chosen component is the rounded
// half root of the branch's trace term, and the other three are element sums
// or differences divided by twice that root, rounded half away from zero. A
// negative scalar part flips the whole quaternion; components saturate. A
// non-positive trace term gives zeros with degenerate set.
// Depends on qfr_pkg, qfr_front, qfr_sqrt, qfr_div and qfr_back.
module quaternion_from_rotation_matrix_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  qfr_pkg::elem_t a00,
	input  qfr_pkg::elem_t a01,
	input  qfr_pkg::elem_t a02,
	input  qfr_pkg::elem_t a10,
	input  qfr_pkg::elem_t a11,
	input  qfr_pkg::elem_t a12,
	input  qfr_pkg::elem_t a20,
	input  qfr_pkg::elem_t a21,
	input  qfr_pkg::elem_t a22,
	output logic           out_valid,
	input  logic           out_ready,
	output qfr_pkg::elem_t quat_w,
	output qfr_pkg::elem_t quat_x,
	output qfr_pkg::elem_t quat_y,
	output qfr_pkg::elem_t quat_z,
	output logic [1:0]     branch,
	output logic           degenerate
);
	import qfr_pkg::*;

	// Front end to square root.
	logic fs_valid, fs_ready;
	sq_t  fs_data;
	// Square root to divider.
	logic sd_valid, sd_ready;
	dv_t  sd_data;
	// Divider to output stage.
	logic db_valid, db_ready;
	dv_t  db_data;

	qfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.a00       (a00),
		.a01       (a01),
		.a02       (a02),
		.a10       (a10),
		.a11       (a11),
		.a12       (a12),
		.a20       (a20),
		.a21       (a21),
		.a22       (a22),
		.out_valid (fs_valid),
		.out_ready (fs_ready),
		.out_data  (fs_data)
	);

	qfr_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fs_valid),
		.in_ready  (fs_ready),
		.in_data   (fs_data),
		.out_valid (sd_valid),
		.out_ready (sd_ready),
		.out_data  (sd_data)
	);

	qfr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sd_valid),
		.in_ready  (sd_ready),
		.in_data   (sd_data),
		.out_valid (db_valid),
		.out_ready (db_ready),
		.out_data  (db_data)
	);

	// The output stage holds a finished word while the stages behind it keep
	// filling.
	qfr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (db_valid),
		.in_ready   (db_ready),
		.in_data    (db_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.quat_w     (quat_w),
		.quat_x     (quat_x),
		.quat_y     (quat_y),
		.quat_z     (quat_z),
		.branch     (branch),
		.degenerate (degenerate)
	);

endmodule

FILE: rtl/core/qfr_chk.sv
// Port-level checker for the quaternion converter, attached by bind.
// Depends on qfr_pkg and quaternion_from_rotation_matrix_top.
module qfr_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input qfr_pkg::elem_t quat_w,
	input qfr_pkg::elem_t quat_x,
	input qfr_pkg::elem_t quat_y,
	input qfr_pkg::elem_t quat_z,
	input logic [1:0]     branch,
	input logic           degenerate
);
	import qfr_pkg::*;

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quat_w) && $stable(quat_x)
			&& $stable(quat_y) && $stable(quat_z) && $stable(branch))
		else $error("stalled result word changed");

	// A degenerate word carries an all-zero quaternion.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> quat_w == 0 && quat_x == 0 && quat_y == 0
			&& quat_z == 0)
		else $error("degenerate word with nonzero quaternion");

	// The scalar part never leaves negative.
	a_w_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> quat_w >= 0)
		else $error("negative scalar part");

	// On the scalar branch the scalar part is the root itself, never zero.
	a_w_branch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate && branch == BR_W |-> quat_w != 0)
		else $error("zero scalar part on scalar branch");

endmodule

bind quaternion_from_rotation_matrix_top qfr_chk u_qfr_chk (.*);

FILE: dv/quaternion_from_rotation_matrix_top_tb.sv
// Self-checking testbench for the rotation-matrix-to-quaternion converter.
// Depends on qfr_pkg and quaternion_from_rotation_matrix_top.
module quaternion_from_rotation_matrix_top_tb;
	import qfr_pkg::*;

	// One matrix word and the quaternion word it should produce.
	typedef struct {
		elem_t e [9];
	} matrix_t;

	typedef struct {
		elem_t   w, x, y, z;
		branch_t br;
		logic    degen;
	} quat_t;

	localparam int LATENCY   = 3 + MW + NW;
	localparam int STALL_MAX = 2000;
	localparam int N_RANDOM  = 1300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	elem_t a00 = '0, a01 = '0, a02 = '0, a10 = '0, a11 = '0, a12 = '0,
		a20 = '0, a21 = '0, a22 = '0;
	logic in_ready, out_valid, degenerate;
	elem_t quat_w, quat_x, quat_y, quat_z;
	logic [1:0] branch;

	matrix_t pending_matrices [$];
	quat_t   expected_quats [$];
	int      mismatches = 0;
	int      n_sent = 0;
	int      n_checked = 0;
	int      n_degen = 0;
	int      branch_hits [4] = '{0, 0, 0, 0};
	bit      stimulus_done = 1'b0;
	bit      quiet_phase = 1'b0;
	int      idle_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	quaternion_from_rotation_matrix_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.a00(a00), .a01(a01), .a02(a02), .a10(a10), .a11(a11),
		.a12(a12), .a20(a20), .a21(a21), .a22(a22),
		.out_valid(out_valid), .out_ready(out_ready),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.branch(branch), .degenerate(degenerate)
	);

	// Floor integer square root by the usual bit-pair method.
	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// d * 4096 / m, rounded to nearest with halves away from zero.
	function automatic longint scaled_quotient(input longint d, input longint unsigned m);
		longint unsigned mag, q;
		mag = (d < 0) ? longint'(-d) : d;
		q = (mag * 4096 + m / 2) / m;
		return (d < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic elem_t clamp16(input longint v);
		longint hi, lo;
		hi = (64'sd1 <<< (DW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return elem_t'(hi);
		if (v < lo) return elem_t'(lo);
		return elem_t'(v);
	endfunction

	// Predicts the quaternion for one matrix word.
	function automatic quat_t predict_quaternion(input matrix_t mx);
		quat_t r;
		longint e [9];
		longint q [4];
		longint t;
		longint unsigned arg, m;
		branch_t br;
		for (int i = 0; i < 9; i++) e[i] = mx.e[i];
		br = BR_W;
		if (e[4] > -e[8] && e[0] > -e[4] && e[0] > -e[8]) br = BR_W;
		else if (e[4] < -e[8] && e[0] > e[4] && e[0] > e[8]) br = BR_X;
		else if (e[4] > e[8] && e[0] < e[4] && e[0] < -e[8]) br = BR_Y;
		else if (e[4] < e[8] && e[0] < -e[4] && e[0] < e[8]) br = BR_Z;
		case (br)
			BR_X: t = 16384 + e[0] - e[4] - e[8];
			BR_Y: t = 16384 + e[4] - e[8] - e[0];
			BR_Z: t = 16384 + e[8] - e[0] - e[4];
			default: t = 16384 + e[0] + e[4] + e[8];
		endcase
		r.br = br;
		r.degen = 1'b0;
		if (t <= 0) begin
			r.w = '0; r.x = '0; r.y = '0; r.z = '0;
			r.degen = 1'b1;
			return r;
		end
		arg = t * 4096;
		m = root_floor(arg);
		if (arg - m * m > m) m++;
		case (br)
			BR_X: begin
				q[1] = m;
				q[0] = scaled_quotient(e[5] - e[7], m);
				q[2] = scaled_quotient(e[1] + e[3], m);
				q[3] = scaled_quotient(e[6] + e[2], m);
			end
			BR_Y: begin
				q[2] = m;
				q[0] = scaled_quotient(e[6] - e[2], m);
				q[1] = scaled_quotient(e[1] + e[3], m);
				q[3] = scaled_quotient(e[5] + e[7], m);
			end
			BR_Z: begin
				q[3] = m;
				q[0] = scaled_quotient(e[1] - e[3], m);
				q[1] = scaled_quotient(e[6] + e[2], m);
				q[2] = scaled_quotient(e[5] + e[7], m);
			end
			default: begin
				q[0] = m;
				q[1] = scaled_quotient(e[5] - e[7], m);
				q[2] = scaled_quotient(e[6] - e[2], m);
				q[3] = scaled_quotient(e[1] - e[3], m);
			end
		endcase
		if (q[0] < 0) for (int i = 0; i < 4; i++) q[i] = -q[i];
		r.w = clamp16(q[0]); r.x = clamp16(q[1]);
		r.y = clamp16(q[2]); r.z = clamp16(q[3]);
		return r;
	endfunction

	function automatic matrix_t uniform_matrix(input elem_t v);
		matrix_t mx;
		for (int i = 0; i < 9; i++) mx.e[i] = v;
		return mx;
	endfunction

	// A random element near a proper rotation value, or anywhere at all.
	function automatic elem_t rand_elem(input bit wild);
		if (wild) return elem_t'($urandom);
		return elem_t'($signed($urandom_range(32768)) - 16384);
	endfunction

	// Builds an approximate rotation from a random unit-ish quaternion, so
	// all four branches and the sign flip are reached with sane magnitudes.
	function automatic matrix_t rotation_like();
		matrix_t mx;
		real w, x, y, z, n, s;
		w = ($itor($urandom_range(2000)) - 1000.0) / 1000.0;
		x = ($itor($urandom_range(2000)) - 1000.0) / 1000.0;
		y = ($itor($urandom_range(2000)) - 1000.0) / 1000.0;
		z = ($itor($urandom_range(2000)) - 1000.0) / 1000.0;
		n = w * w + x * x + y * y + z * z;
		if (n < 1e-3) begin
			w = 1.0; n = 1.0;
		end
		s = 2.0 * 16383.0 / n;
		mx.e[0] = elem_t'($rtoi(16383.0 - s * (y * y + z * z)));
		mx.e[1] = elem_t'($rtoi(s * (x * y - z * w)));
		mx.e[2] = elem_t'($rtoi(s * (x * z + y * w)));
		mx.e[3] = elem_t'($rtoi(s * (x * y + z * w)));
		mx.e[4] = elem_t'($rtoi(16383.0 - s * (x * x + z * z)));
		mx.e[5] = elem_t'($rtoi(s * (y * z - x * w)));
		mx.e[6] = elem_t'($rtoi(s * (x * z - y * w)));
		mx.e[7] = elem_t'($rtoi(s * (y * z + x * w)));
		mx.e[8] = elem_t'($rtoi(16383.0 - s * (x * x + y * y)));
		return mx;
	endfunction

	// Stimulus: a directed set first, then random words.
	initial begin
		matrix_t mx;
		pending_matrices.push_back(uniform_matrix(16'sh0000));
		mx = uniform_matrix(16'sh0000);
		mx.e[0] = 16'sd16384; mx.e[4] = 16'sd16384; mx.e[8] = 16'sd16384;
		pending_matrices.push_back(mx);                 // identity
		mx = uniform_matrix(16'sh0000);
		mx.e[0] = 16'sd16384; mx.e[4] = -16'sd16384; mx.e[8] = -16'sd16384;
		pending_matrices.push_back(mx);                 // half turn about x
		mx = uniform_matrix(16'sh0000);
		mx.e[0] = -16'sd16384; mx.e[4] = 16'sd16384; mx.e[8] = -16'sd16384;
		pending_matrices.push_back(mx);                 // half turn about y
		mx = uniform_matrix(16'sh0000);
		mx.e[0] = -16'sd16384; mx.e[4] = -16'sd16384; mx.e[8] = 16'sd16384;
		pending_matrices.push_back(mx);                 // half turn about z
		pending_matrices.push_back(uniform_matrix(16'sh7fff));
		pending_matrices.push_back(uniform_matrix(16'sh8000));
		pending_matrices.push_back(uniform_matrix(16'shffff));
		mx = uniform_matrix(16'sh8000);
		mx.e[4] = 16'sh7fff;
		pending_matrices.push_back(mx);                 // extreme diagonal, the y branch test holds
		mx = uniform_matrix(16'sh0000);
		mx.e[0] = -16'sd16384; mx.e[4] = -16'sd16384; mx.e[8] = -16'sd16384;
		pending_matrices.push_back(mx);                 // non-positive trace term
		mx = uniform_matrix(16'sh0000);
		mx.e[0] = -16'sd16384; mx.e[4] = 16'sd1; mx.e[8] = 16'sd1;
		mx.e[5] = 16'sh7fff; mx.e[7] = 16'sh8000;
		pending_matrices.push_back(mx);                 // saturation, tiny root
		mx = uniform_matrix(16'sh0000);
		mx.e[0] = 16'sd16384; mx.e[4] = 16'sd16384; mx.e[8] = 16'sd16384;
		mx.e[5] = 16'sh8000; mx.e[7] = 16'sh7fff;
		mx.e[1] = 16'sh7fff; mx.e[3] = 16'sh8000;
		pending_matrices.push_back(mx);
		mx = uniform_matrix(16'sh0000);
		mx.e[0] = 16'sh8000; mx.e[4] = 16'sh7fff; mx.e[8] = 16'sh8000;
		mx.e[6] = 16'sh8000; mx.e[2] = 16'sh7fff;
		pending_matrices.push_back(mx);                 // negative scalar flip
		for (int i = 0; i < 8; i++) pending_matrices.push_back(rotation_like());
		for (int i = 0; i < N_RANDOM; i++) begin
			case ($urandom_range(9))
				0, 1: begin
					for (int k = 0; k < 9; k++) mx.e[k] = rand_elem(1'b1);
				end
				2, 3: begin
					for (int k = 0; k < 9; k++) mx.e[k] = rand_elem(1'b0);
				end
				default: mx = rotation_like();
			endcase
			pending_matrices.push_back(mx);
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: presents the head of the queue and drops it on acceptance.
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_quats.push_back(predict_quaternion(pending_matrices.pop_front()));
				n_sent++;
			end
			quiet_phase <= (pending_matrices.size() < 150);
			if (!(in_valid && !in_ready)) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (!quiet_phase && $urandom_range(7) == 0) begin
					send_gap <= $urandom_range(15, 1) - 1;
					in_valid <= 1'b0;
				end else if (pending_matrices.size() > 0) begin
					in_valid <= 1'b1;
					a00 <= pending_matrices[0].e[0]; a01 <= pending_matrices[0].e[1];
					a02 <= pending_matrices[0].e[2]; a10 <= pending_matrices[0].e[3];
					a11 <= pending_matrices[0].e[4]; a12 <= pending_matrices[0].e[5];
					a20 <= pending_matrices[0].e[6]; a21 <= pending_matrices[0].e[7];
					a22 <= pending_matrices[0].e[8];
				end else begin
					in_valid <= 1'b0;
					stimulus_done <= 1'b1;
				end
			end
		end
	end

	// Monitor: compares each accepted quaternion with the oldest prediction
	// and draws random stall bursts on the output side.
	int stall_left = 0;
	always @(posedge clk) begin
		quat_t exp_q;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_quats.size() == 0) begin
					$display("%0t: unexpected quaternion word w=%0d", $time, quat_w);
					mismatches++;
				end else begin
					exp_q = expected_quats.pop_front();
					if (quat_w !== exp_q.w || quat_x !== exp_q.x || quat_y !== exp_q.y ||
						quat_z !== exp_q.z || branch !== exp_q.br ||
						degenerate !== exp_q.degen) begin
						$display("%0t: expected w=%0d x=%0d y=%0d z=%0d br=%0d dg=%0d", $time,
							exp_q.w, exp_q.x, exp_q.y, exp_q.z, exp_q.br, exp_q.degen);
						$display("%0t: actual   w=%0d x=%0d y=%0d z=%0d br=%0d dg=%0d", $time,
							quat_w, quat_x, quat_y, quat_z, branch, degenerate);
						mismatches++;
					end
					n_checked++;
					branch_hits[exp_q.br]++;
					if (exp_q.degen) n_degen++;
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (!quiet_phase && $urandom_range(7) == 0) begin
				stall_left <= $urandom_range(15, 1) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no handshake on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else if (arst_n && !stimulus_done) idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_MAX) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// End of run: drain, allow the pipeline to settle, then report.
	initial begin
		int waited;
		waited = 0;
		wait (stimulus_done);
		while (expected_quats.size() != 0 && waited < 20 * STALL_MAX) begin
			@(posedge clk);
			waited++;
		end
		repeat (2 * LATENCY) @(posedge clk);
		$display("Checked %0d of %0d matrices; branches 0..3 seen %0d/%0d/%0d/%0d, %0d degenerate.",
			n_checked, n_sent, branch_hits[0], branch_hits[1], branch_hits[2],
			branch_hits[3], n_degen);
		if (expected_quats.size() != 0) begin
			$display("%0t: %0d predicted quaternions never arrived", $time,
				expected_quats.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
